>>> hw/rtl/ookpw_pkg.sv
// ----------------------------------------------------------------------------
// ookpw_pkg
// Shared types, constants and the CRC-8 byte function of the pulse-width
// on-off-keyed frame transmitter.
// ----------------------------------------------------------------------------
package ookpw_pkg;

    localparam int FRAME_BYTES = 6;
    localparam int TEMP_W      = 12;

    // Index of the CRC byte in the frame; the CRC covers the three bytes before it.
    localparam logic [2:0] CRC_BYTE_IDX = 3'd5;
    localparam logic [1:0] CRC_SPAN     = 2'd3;

    localparam logic [7:0] CRC_POLY     = 8'h31;
    localparam logic [7:0] CRC_INIT     = 8'h00;
    localparam logic [7:0] BIT_MASK_MSB = 8'h80;

    localparam logic [7:0] PREAMBLE_RESET  = 8'hFF;
    localparam logic [7:0] DEVICE_ID_RESET = 8'h00;
    localparam logic [3:0] CHANNEL_RESET   = 4'h0;

    // Pulse timing: a zero stays high for this many ticks.
    localparam logic [1:0] ZERO_HIGH_TICKS = 2'd3;

    typedef enum logic {
        OP_TICK = 1'b0,
        OP_LOAD = 1'b1
    } op_e;

    typedef enum logic [1:0] {
        REG_PREAMBLE  = 2'd0,
        REG_DEVICE_ID = 2'd1,
        REG_CHANNEL   = 2'd2
    } cfg_reg_e;

    typedef enum logic [2:0] {
        ST_IDLE      = 3'd0,
        ST_NEXT_BYTE = 3'd1,
        ST_NEXT_BIT  = 3'd2,
        ST_SEND_ONE  = 3'd3,
        ST_SEND_ZERO = 3'd4,
        ST_SPACE     = 3'd5
    } sender_state_t;

    typedef logic [FRAME_BYTES-1:0][7:0] frame_t;

    // Status of the sender as seen by the top level.
    typedef struct packed {
        logic pending;
        logic rf_next;
        logic led_next;
        logic pending_next;
    } sender_stat_t;

    // CRC-8, MSB first, no reflection, over one data byte.
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
        logic [7:0] c;
        logic [7:0] d;
        logic       top;
        c = crc_in;
        d = data;
        for (int i = 0; i < 8; i++)
        begin
            top = c[7] ^ d[7];
            c   = {c[6:0], 1'b0};
            if (top)
            begin
                c = c ^ CRC_POLY;
            end
            d = {d[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

>>> hw/rtl/ookpw_in_if.sv
// ----------------------------------------------------------------------------
// ookpw_in_if
// Request channel into the transmitter: tick or load with the sensor fields.
// ----------------------------------------------------------------------------
interface ookpw_in_if;
    import ookpw_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     op;
    logic signed [TEMP_W-1:0] temperature;
    logic        [1:0]        heat_bits;
    logic        [1:0]        cool_bits;

    modport source (output valid, output op, output temperature,
                    output heat_bits, output cool_bits, input ready);
    modport sink   (input valid, input op, input temperature,
                    input heat_bits, input cool_bits, output ready);
endinterface

>>> hw/rtl/ookpw_out_if.sv
// ----------------------------------------------------------------------------
// ookpw_out_if
// Result channel out of the transmitter: line levels and status per request.
// ----------------------------------------------------------------------------
interface ookpw_out_if;
    logic valid;
    logic ready;
    logic rf_level;
    logic front_led;
    logic busy_res;
    logic load_accepted;

    modport source (output valid, output rf_level, output front_led,
                    output busy_res, output load_accepted, input ready);
    modport sink   (input valid, input rf_level, input front_led,
                    input busy_res, input load_accepted, output ready);
endinterface

>>> hw/rtl/ook_pulse_width_frame_transmitter_unit.sv
// ----------------------------------------------------------------------------
// ook_pulse_width_frame_transmitter_unit
// Pulse-width on-off-keyed transmitter for a six-byte sensor frame with a
// CRC-8 trailer; each tick request steps the line.
// ----------------------------------------------------------------------------
//
//   Channel  | Direction | Handshake     | Payload
//   ---------+-----------+---------------+----------------------------------------
//   in_ch    | in        | valid/ready   | op, temperature, heat_bits, cool_bits
//   out_ch   | out       | valid/ready   | rf_level, front_led, busy_res, load_accepted
//   cfg      | in        | cfg_we only   | cfg_index, cfg_data (8 bits)
//
// When a request is accepted, the sender or the frame
// store is updated at that edge, and its result sits in the output register
// from the next cycle on. A new request can follow in every cycle in which
// the input is ready, which it is whenever the output register is empty or
// being drained, so a stalled result holds back only the request behind it.
// Reset clears the sender, the flags and the output valid bit; the frame
// store is written by the first load before anything reads it.
// ----------------------------------------------------------------------------
module ook_pulse_width_frame_transmitter_unit (
    input  logic        clk,
    input  logic        rst_n,
    ookpw_in_if.sink    in_ch,
    ookpw_out_if.source out_ch,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import ookpw_pkg::*;

    logic         in_fire;
    logic         is_load;
    logic         load_go;
    logic         step;
    frame_t       frame;
    logic         crc_busy;
    sender_stat_t stat;

    logic out_valid_reg;
    logic rf_level_reg;
    logic front_led_reg;
    logic busy_res_reg;
    logic load_accepted_reg;

    // The input side waits only when a finished result has not been taken.
    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign is_load     = (in_ch.op == OP_LOAD);

    // A load while a frame is still pending or going out is dropped.
    assign load_go = in_fire && is_load && !stat.pending;
    assign step    = in_fire && !is_load;

    ookpw_frame_builder u_builder (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .load_go     (load_go),
        .temperature (in_ch.temperature),
        .heat_bits   (in_ch.heat_bits),
        .cool_bits   (in_ch.cool_bits),
        .frame       (frame),
        .crc_busy    (crc_busy)
    );

    ookpw_sender u_sender (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .load_go (load_go),
        .frame   (frame),
        .stat    (stat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // The result carries the levels and flags as they stand after the request.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            rf_level_reg      <= stat.rf_next;
            front_led_reg     <= stat.led_next;
            busy_res_reg      <= stat.pending_next;
            load_accepted_reg <= load_go;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.rf_level      = rf_level_reg;
    assign out_ch.front_led     = front_led_reg;
    assign out_ch.busy_res      = busy_res_reg;
    assign out_ch.load_accepted = load_accepted_reg;

`ifndef SYNTHESIS
    // Every accepted request leaves a result in the output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> out_valid_reg)
        else $error("accepted request produced no result");

    // A started frame always reports the transmitter as busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && load_accepted_reg) |-> busy_res_reg)
        else $error("load accepted but busy not reported");

    // The CRC is folded in only while its frame is pending.
    assert property (@(posedge clk) disable iff (!rst_n)
        crc_busy |-> stat.pending)
        else $error("CRC update without a pending frame");
`endif

endmodule

>>> hw/rtl/ookpw_frame_builder.sv
// ----------------------------------------------------------------------------
// ookpw_frame_builder
// Configuration registers, the six-byte frame store and a CRC-8 unit that
// folds in one byte per clock after a load.
// ----------------------------------------------------------------------------
module ookpw_frame_builder (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [1:0]                      cfg_index,
    input  logic [7:0]                      cfg_data,
    input  logic                            load_go,
    input  logic signed [ookpw_pkg::TEMP_W-1:0] temperature,
    input  logic [1:0]                      heat_bits,
    input  logic [1:0]                      cool_bits,
    output ookpw_pkg::frame_t               frame,
    output logic                            crc_busy
);
    import ookpw_pkg::*;

    logic [7:0] preamble_reg;
    logic [7:0] device_id_reg;
    logic [3:0] channel_reg;

    frame_t     frame_reg;
    logic [7:0] crc_reg;
    logic [7:0] crc_next;
    logic [1:0] crc_cnt_reg;
    logic [2:0] crc_idx;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            preamble_reg  <= PREAMBLE_RESET;
            device_id_reg <= DEVICE_ID_RESET;
            channel_reg   <= CHANNEL_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PREAMBLE:  preamble_reg  <= cfg_data;
                REG_DEVICE_ID: device_id_reg <= cfg_data;
                REG_CHANNEL:   channel_reg   <= cfg_data[3:0];
                default:       ;
            endcase
        end
    end

    // The count walks bytes 2, 3 and 4 in order.
    assign crc_idx  = CRC_BYTE_IDX - {1'b0, crc_cnt_reg};
    assign crc_next = crc8_byte(crc_reg, frame_reg[crc_idx]);
    assign crc_busy = (crc_cnt_reg != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_cnt_reg <= 2'd0;
        end
        else if (load_go)
        begin
            crc_cnt_reg <= CRC_SPAN;
        end
        else if (crc_busy)
        begin
            crc_cnt_reg <= crc_cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_go)
        begin
            frame_reg[0] <= preamble_reg;
            frame_reg[1] <= device_id_reg;
            frame_reg[2] <= {channel_reg, temperature[11:8]};
            frame_reg[3] <= temperature[7:0];
            frame_reg[4] <= {heat_bits, cool_bits, 4'h0};
            crc_reg      <= CRC_INIT;
        end
        else if (crc_busy)
        begin
            crc_reg <= crc_next;
            if (crc_cnt_reg == 2'd1)
            begin
                frame_reg[CRC_BYTE_IDX] <= crc_next;
            end
        end
    end

    assign frame = frame_reg;

endmodule

>>> hw/rtl/ookpw_sender.sv
// ----------------------------------------------------------------------------
// ookpw_sender
// Tick-driven state machine that shifts the frame out as pulse widths and
// owns the line, LED and pending flags.
// ----------------------------------------------------------------------------
module ookpw_sender (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    step,
    input  logic                    load_go,
    input  ookpw_pkg::frame_t       frame,
    output ookpw_pkg::sender_stat_t stat
);
    import ookpw_pkg::*;

    sender_state_t state_reg;
    sender_state_t state_next;
    logic [7:0]    mask_reg;
    logic [7:0]    mask_next;
    logic [2:0]    idx_reg;
    logic [2:0]    idx_next;
    logic [2:0]    idx_m1;
    logic [1:0]    hcnt_reg;
    logic [1:0]    hcnt_next;
    logic          pending_reg;
    logic          pending_next;
    logic          rf_reg;
    logic          rf_next;
    logic          led_reg;
    logic          led_next;
    logic [7:0]    cur_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            mask_reg    <= 8'h00;
            idx_reg     <= 3'd0;
            hcnt_reg    <= 2'd0;
            pending_reg <= 1'b0;
            rf_reg      <= 1'b0;
            led_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            mask_reg    <= mask_next;
            idx_reg     <= idx_next;
            hcnt_reg    <= hcnt_next;
            pending_reg <= pending_next;
            rf_reg      <= rf_next;
            led_reg     <= led_next;
        end
    end

    // Byte being sent; an index outside the frame reads as zero.
    assign idx_m1 = idx_reg - 3'd1;
    always_comb
    begin
        cur_byte = 8'h00;
        if (idx_reg >= 3'd1 && idx_reg <= 3'(FRAME_BYTES))
        begin
            cur_byte = frame[idx_m1];
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        mask_next    = mask_reg;
        idx_next     = idx_reg;
        hcnt_next    = hcnt_reg;
        pending_next = pending_reg;
        rf_next      = rf_reg;
        led_next     = led_reg;
        if (load_go)
        begin
            pending_next = 1'b1;
        end
        else if (step)
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    led_next = 1'b0;
                    idx_next = 3'd0;
                    if (pending_reg)
                    begin
                        state_next = ST_NEXT_BYTE;
                    end
                end
                ST_NEXT_BYTE:
                begin
                    led_next  = 1'b1;
                    mask_next = BIT_MASK_MSB;
                    idx_next  = idx_reg + 3'd1;
                    if (idx_next > 3'(FRAME_BYTES) || idx_next == 3'd0)
                    begin
                        pending_next = 1'b0;
                        state_next   = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_NEXT_BIT;
                    end
                end
                ST_NEXT_BIT:
                begin
                    rf_next = 1'b0;
                    if (mask_reg == 8'h00)
                    begin
                        state_next = ST_NEXT_BYTE;
                    end
                    else if ((cur_byte & mask_reg) != 8'h00)
                    begin
                        state_next = ST_SEND_ONE;
                    end
                    else
                    begin
                        hcnt_next  = 2'd0;
                        state_next = ST_SEND_ZERO;
                    end
                end
                ST_SEND_ONE:
                begin
                    rf_next    = 1'b1;
                    hcnt_next  = 2'd0;
                    state_next = ST_SPACE;
                end
                ST_SEND_ZERO:
                begin
                    rf_next   = 1'b1;
                    hcnt_next = hcnt_reg + 2'd1;
                    if (hcnt_next == ZERO_HIGH_TICKS)
                    begin
                        hcnt_next  = 2'd0;
                        state_next = ST_SPACE;
                    end
                end
                ST_SPACE:
                begin
                    rf_next    = 1'b0;
                    mask_next  = {1'b0, mask_reg[7:1]};
                    state_next = ST_NEXT_BIT;
                end
                default:
                begin
                    state_next = ST_IDLE;
                end
            endcase
        end
    end

    assign stat.pending      = pending_reg;
    assign stat.rf_next      = rf_next;
    assign stat.led_next     = led_next;
    assign stat.pending_next = pending_next;

`ifndef SYNTHESIS
    // Outside idle the sender is always working on a pending frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> pending_reg)
        else $error("sender active without a pending frame");

    // A zero pulse never counts past its high time.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEND_ZERO) |-> (hcnt_reg != ZERO_HIGH_TICKS))
        else $error("zero pulse high count overran");

    // While a bit is in flight the byte index points inside the frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_NEXT_BIT) |-> (idx_reg >= 3'd1 && idx_reg <= 3'(FRAME_BYTES)))
        else $error("byte index outside the frame while sending");
`endif

endmodule
